/* design/gda_pkg.sv */
package gda_pkg;

   // Top of the year range and width of the signed day offset
   localparam int YEAR_MAX     = 9999;
   localparam int OFFSET_WIDTH = 24;

   // Year arithmetic width: covers the 14-bit input years and YEAR_MAX + 1
   localparam int YB_W  = $clog2(YEAR_MAX + 2);
   localparam int Y_W   = (YB_W > 14) ? YB_W : 14;
   localparam int DBY_W = Y_W + 9;
   localparam int N_W   = ((DBY_W > OFFSET_WIDTH) ? DBY_W : OFFSET_WIDTH) + 2;

   // x / 100 as (x * RCP_100) >> RCP_SH, exact for x below 2**RCP_SH / 84
   localparam int RCP_SH  = 24;
   localparam int RCP_100 = ((2 ** RCP_SH) + 99) / 100;
   localparam int RCP_W   = $clog2(RCP_100 + 1);
   localparam int YS_W    = Y_W + 2;
   localparam int PR_W    = YS_W + RCP_W;

   // Year estimate n * 400 / 146097 as (n * YR_RCP) >> YR_SH, rounded down;
   // the adjust loops settle the last year or two
   localparam int YR_SH  = 24;
   localparam int YR_RCP = 45934;
   localparam int YP_W   = DBY_W + 16;

   localparam int CYCLE_DAYS = 146097;
   localparam int TOP_DAY    = 365 * (YEAR_MAX + 1) + (YEAR_MAX + 4) / 4
                               - (YEAR_MAX + 100) / 100 + (YEAR_MAX + 400) / 400 - 1;

   localparam int REQ_FIELDS_W = 46 + OFFSET_WIDTH;
   localparam int REQ_W        = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_W        = 48;
   localparam int DIFF_W       = 22;

   localparam logic [1:0] CMP_EQ = 2'd0;
   localparam logic [1:0] CMP_LT = 2'd1;
   localparam logic [1:0] CMP_GT = 2'd2;

   localparam logic [4:0] MONTH_LEN [13] = '{5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31,
                                             5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30,
                                             5'd31};

   typedef enum logic [1:0] {
      OP_ADD  = 2'd0,
      OP_SUB  = 2'd1,
      OP_CMP  = 2'd2,
      OP_DIFF = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_DN_LO,
      ST_DN_LEAP,
      ST_DN_SUM,
      ST_LOAD_B,
      ST_OFS,
      ST_CLAMP,
      ST_Q2Y,
      ST_ADJ_LO,
      ST_ADJ_HI,
      ST_MONTH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load_req;
      logic dn_lo;
      logic dn_leap;
      logic dn_sum;
      logic load_b;
      logic apply_ofs;
      logic clamp;
      logic q2y;
      logic adj_lo;
      logic adj_hi;
      logic month_step;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      op_type op;
      logic   sel_b;
      logic   out_of_range;
      logic   adj_down;
      logic   adj_up;
      logic   month_more;
   } dp_stat_type;

   // Days from 0000-01-01 to the first day of year y
   function automatic logic [DBY_W-1:0] days_before_year(input logic [Y_W:0] y);
      logic [YS_W-1:0] y3;
      logic [YS_W-1:0] y99;
      logic [YS_W-1:0] y399;
      logic [PR_W-1:0] p100;
      logic [PR_W-1:0] p400;
      y3   = YS_W'(y) + YS_W'(3);
      y99  = YS_W'(y) + YS_W'(99);
      y399 = YS_W'(y) + YS_W'(399);
      p100 = PR_W'(y99) * PR_W'(RCP_100);
      p400 = PR_W'(y399 >> 2) * PR_W'(RCP_100);
      return DBY_W'(y) * DBY_W'(365) + DBY_W'(y3 >> 2)
             - DBY_W'(p100 >> RCP_SH) + DBY_W'(p400 >> RCP_SH);
   endfunction

   // Days in the year before the first of month m (m in 1..12)
   function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
      logic [8:0] c;
      unique case (m)
         4'd1:    c = 9'd0;
         4'd2:    c = 9'd31;
         4'd3:    c = 9'd59;
         4'd4:    c = 9'd90;
         4'd5:    c = 9'd120;
         4'd6:    c = 9'd151;
         4'd7:    c = 9'd181;
         4'd8:    c = 9'd212;
         4'd9:    c = 9'd243;
         4'd10:   c = 9'd273;
         4'd11:   c = 9'd304;
         4'd12:   c = 9'd334;
         default: c = 9'd0;
      endcase
      if (leap && m > 4'd2) begin
         c = c + 9'd1;
      end
      return c;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      if (m > 4'd12) begin
         len = MONTH_LEN[1];
      end else begin
         len = MONTH_LEN[m];
      end
      if (leap && m == 4'd2) begin
         len = 5'd29;
      end
      return len;
   endfunction

endpackage

/* design/gda_ctrl.sv */
module gda_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  gda_pkg::dp_stat_type stat,
   output gda_pkg::dp_cmd_type  cmd
);
   import gda_pkg::*;

   state_type        state_ff;
   state_type        state_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             rsp_free;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = (stat.op == OP_CMP) ? ST_DONE : ST_DN_LO;
         end
         ST_DN_LO:   state_in = ST_DN_LEAP;
         ST_DN_LEAP: state_in = ST_DN_SUM;
         ST_DN_SUM: begin
            priority if (stat.op == OP_ADD || stat.op == OP_SUB) begin
               state_in = ST_OFS;
            end else if (!stat.sel_b) begin
               state_in = ST_LOAD_B;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_LOAD_B: state_in = ST_DN_LO;
         ST_OFS:    state_in = ST_CLAMP;
         ST_CLAMP: begin
            state_in = stat.out_of_range ? ST_DONE : ST_Q2Y;
         end
         ST_Q2Y: state_in = ST_ADJ_LO;
         ST_ADJ_LO: begin
            if (!stat.adj_down) begin
               state_in = ST_ADJ_HI;
            end
         end
         ST_ADJ_HI: begin
            if (!stat.adj_up) begin
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            if (!stat.month_more) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE:    cmd.load_req   = req_tvalid;
         ST_DN_LO:   cmd.dn_lo      = 1'b1;
         ST_DN_LEAP: cmd.dn_leap    = 1'b1;
         ST_DN_SUM:  cmd.dn_sum     = 1'b1;
         ST_LOAD_B:  cmd.load_b     = 1'b1;
         ST_OFS:     cmd.apply_ofs  = 1'b1;
         ST_CLAMP:   cmd.clamp      = 1'b1;
         ST_Q2Y:     cmd.q2y        = 1'b1;
         ST_ADJ_LO:  cmd.adj_lo     = 1'b1;
         ST_ADJ_HI:  cmd.adj_hi     = 1'b1;
         ST_MONTH:   cmd.month_step = 1'b1;
         ST_DONE:    cmd.load_rsp   = rsp_free;
         default:    cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_one_request_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while another is in work");

   a_rsp_only_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == ST_DONE)
      else $error("response raised outside the done state");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("response dropped while waiting");
`endif

endmodule

/* design/gda_dpath.sv */
module gda_dpath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [gda_pkg::REQ_W-1:0]   req_tdata,
   input  logic [1:0]                  req_tuser,
   output logic [gda_pkg::RSP_W-1:0]   rsp_tdata,
   input  gda_pkg::dp_cmd_type         cmd,
   output gda_pkg::dp_stat_type        stat
);
   import gda_pkg::*;

   op_type                   op_ff;
   logic [13:0]              a_year_ff;
   logic [3:0]               a_month_ff;
   logic [4:0]               a_day_ff;
   logic [13:0]              b_year_ff;
   logic [3:0]               b_month_ff;
   logic [4:0]               b_day_ff;
   logic signed [OFFSET_WIDTH-1:0] off_ff;
   logic                     sel_b_ff;

   logic [Y_W:0]             y_ff;
   logic [DBY_W-1:0]         lo_ff;
   logic                     leap_ff;
   logic signed [N_W-1:0]    n_ff;
   logic signed [N_W-1:0]    na_ff;
   logic [3:0]               m_ff;
   logic [1:0]               ovf_ff;
   logic [Y_W-1:0]           q_ff;
   logic [RSP_W-1:0]         rsp_ff;

   logic [Y_W:0]             dby_arg;
   logic [DBY_W-1:0]         dby_val;
   logic [DBY_W-1:0]         n_u;
   logic [YP_W-1:0]          y_prod;
   logic [3:0]               m_raw;
   logic [3:0]               m_clip;
   logic [4:0]               d_sel;
   logic signed [N_W-1:0]    n_dn;
   logic signed [N_W-1:0]    off_x;
   logic                     n_neg;
   logic                     n_above;
   logic [4:0]               len_cur;
   logic [22:0]              key_a;
   logic [22:0]              key_b;
   logic [1:0]               cmp_val;
   logic [N_W-1:0]           diff_abs;
   logic [DIFF_W-1:0]        diff_val;
   logic [RSP_W-1:0]         rsp_in;

   // One shared year-start unit; the upward adjust and leap steps look one year ahead
   assign dby_arg = (cmd.dn_leap || cmd.adj_hi) ? (y_ff + (Y_W+1)'(1)) : y_ff;
   assign dby_val = days_before_year(dby_arg);

   assign n_u     = n_ff[DBY_W-1:0];
   assign y_prod  = YP_W'(n_u) * YP_W'(YR_RCP);
   assign m_raw   = sel_b_ff ? b_month_ff : a_month_ff;
   assign d_sel   = sel_b_ff ? b_day_ff : a_day_ff;
   assign m_clip  = (m_raw == 4'd0) ? 4'd1 : ((m_raw > 4'd12) ? 4'd12 : m_raw);
   assign n_dn    = signed'(N_W'(lo_ff) + N_W'(cum_days(m_clip, leap_ff))
                            + N_W'(d_sel) - N_W'(1));
   assign off_x   = N_W'(off_ff);
   assign n_neg   = n_ff[N_W-1];
   assign n_above = n_ff > N_W'(TOP_DAY);
   assign len_cur = month_len(m_ff, leap_ff);

   assign stat.op           = op_ff;
   assign stat.sel_b        = sel_b_ff;
   assign stat.out_of_range = n_neg || n_above;
   assign stat.adj_down     = (dby_val > n_u) && (y_ff != '0);
   assign stat.adj_up       = dby_val <= n_u;
   assign stat.month_more   = (m_ff < 4'd12) && (n_u >= DBY_W'(len_cur));

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff      <= op_type'(req_tuser);
         a_year_ff  <= req_tdata[13:0];
         a_month_ff <= req_tdata[17:14];
         a_day_ff   <= req_tdata[22:18];
         b_year_ff  <= req_tdata[36:23];
         b_month_ff <= req_tdata[40:37];
         b_day_ff   <= req_tdata[45:41];
         off_ff     <= req_tdata[46 +: OFFSET_WIDTH];
         y_ff       <= (Y_W+1)'(req_tdata[13:0]);
         sel_b_ff   <= 1'b0;
      end else if (cmd.dn_lo) begin
         lo_ff <= dby_val;
      end else if (cmd.dn_leap) begin
         leap_ff <= (dby_val - lo_ff) == DBY_W'(366);
      end else if (cmd.dn_sum) begin
         n_ff <= n_dn;
      end else if (cmd.load_b) begin
         na_ff    <= n_ff;
         y_ff     <= (Y_W+1)'(b_year_ff);
         sel_b_ff <= 1'b1;
      end else if (cmd.apply_ofs) begin
         n_ff <= (op_ff == OP_SUB) ? (n_ff - off_x) : (n_ff + off_x);
      end else if (cmd.clamp) begin
         ovf_ff <= {n_above, n_neg};
         q_ff   <= y_prod[YR_SH +: Y_W];
      end else if (cmd.q2y) begin
         y_ff <= (Y_W+1)'(q_ff);
      end else if (cmd.adj_lo) begin
         // step back while the year starts after the day number
         if (stat.adj_down) begin
            y_ff <= y_ff - (Y_W+1)'(1);
         end else begin
            lo_ff <= dby_val;
         end
      end else if (cmd.adj_hi) begin
         if (stat.adj_up) begin
            y_ff  <= y_ff + (Y_W+1)'(1);
            lo_ff <= dby_val;
         end else begin
            leap_ff <= (dby_val - lo_ff) == DBY_W'(366);
            n_ff    <= n_ff - signed'(N_W'(lo_ff));
            m_ff    <= 4'd1;
         end
      end else if (cmd.month_step) begin
         if (stat.month_more) begin
            n_ff <= n_ff - signed'(N_W'(len_cur));
            m_ff <= m_ff + 4'd1;
         end
      end
   end

   assign key_a   = {a_year_ff, a_month_ff, a_day_ff};
   assign key_b   = {b_year_ff, b_month_ff, b_day_ff};
   assign cmp_val = (key_a == key_b) ? CMP_EQ : ((key_a < key_b) ? CMP_LT : CMP_GT);

   assign diff_abs = (na_ff > n_ff) ? N_W'(na_ff - n_ff) : N_W'(n_ff - na_ff);
   assign diff_val = (diff_abs > N_W'({DIFF_W{1'b1}})) ? {DIFF_W{1'b1}}
                                                        : diff_abs[DIFF_W-1:0];

   // Response fields from bit 0: year, month, day, compare, difference, overflow
   always_comb begin
      rsp_in = '0;
      unique case (op_ff)
         OP_ADD, OP_SUB: begin
            priority if (ovf_ff[0]) begin
               rsp_in[13:0]  = 14'd0;
               rsp_in[17:14] = 4'd1;
               rsp_in[22:18] = 5'd1;
               rsp_in[47]    = 1'b1;
            end else if (ovf_ff[1]) begin
               rsp_in[13:0]  = 14'(YEAR_MAX);
               rsp_in[17:14] = 4'd12;
               rsp_in[22:18] = 5'd31;
               rsp_in[47]    = 1'b1;
            end else begin
               rsp_in[13:0]  = y_ff[13:0];
               rsp_in[17:14] = m_ff;
               rsp_in[22:18] = n_u[4:0] + 5'd1;
            end
         end
         OP_CMP:  rsp_in[24:23] = cmp_val;
         OP_DIFF: rsp_in[46:25] = diff_val;
         default: rsp_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tdata = rsp_ff;

`ifndef SYNTHESIS
   a_quotient_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.q2y |-> q_ff <= (Y_W)'(YEAR_MAX + 1))
      else $error("year estimate beyond range");

   a_year_found: assert property (@(posedge clock) disable iff (reset)
      (cmd.adj_hi && !stat.adj_up) |-> (n_u >= lo_ff) && (n_u - lo_ff < DBY_W'(366)))
      else $error("day number not inside the found year");

   a_month_walk_range: assert property (@(posedge clock) disable iff (reset)
      cmd.month_step |-> (m_ff >= 4'd1) && (m_ff <= 4'd12))
      else $error("month walk out of range");
`endif

endmodule

/* design/gregorian_date_arithmetic.sv */
// Gregorian date engine (proleptic calendar, year 0 is a leap year). A request
// carries an operation on req_tuser and two dates plus a signed day offset on
// req_tdata; exactly one response follows each request, in order. Add and
// subtract convert date A to a day number, apply the offset, then split the
// number back into a date: a multiply by the reciprocal of the 400-year cycle
// estimates the year, a short adjust loop fixes it against the shared
// year-start unit, and the month is found by stepping one month per cycle.
// Results outside years 0..YEAR_MAX saturate and set year_overflow. How long
// an add or subtract takes depends on the month walk and the year adjust.
// One request is in work at a time, and a new one is taken while the last
// response waits.
module gregorian_date_arithmetic (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // a_year, a_month, a_day, b_year, b_month, b_day, offset_days, zero fill
   input  logic [gda_pkg::REQ_W-1:0] req_tdata,
   // req_type
   input  logic [1:0]                req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // res_year, res_month, res_day, cmp_code, diff_days, year_overflow
   output logic [gda_pkg::RSP_W-1:0] rsp_tdata
);
   import gda_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   gda_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   gda_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule
